[rtl/graph_bfs_dfs_traversal_macros.svh]
// ----------------------------------------------------------------------------
// Graph traversal assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gbt_pkg.sv]
// ----------------------------------------------------------------------------
// Graph traversal package
// Shared widths, request and register codes, and the payload and control
// structs of the graph traversal block.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int unsigned MaxVerticesDefault = 16;
  localparam int unsigned FieldLimit         = 16;
  localparam int unsigned VtxW               = 4;
  localparam int unsigned CntW               = 5;
  localparam int unsigned ReqW               = 2;
  localparam int unsigned CfgIdxW            = 1;
  localparam int unsigned CfgDataW           = 5;

  localparam logic [CntW-1:0] VertexCountReset = 5'd16;

  typedef logic [ReqW-1:0] req_t;
  localparam req_t ReqClear = 2'd0;
  localparam req_t ReqEdge  = 2'd1;
  localparam req_t ReqWalk  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgVertexCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgWalkMode    = 1'd1;

  localparam logic ModeBreadth = 1'b0;
  localparam logic ModeDepth   = 1'b1;

  typedef struct packed {
    req_t            req_type;
    logic [VtxW-1:0] first_vertex;
    logic [VtxW-1:0] second_vertex;
  } gbt_in_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            last;
    logic            error;
  } gbt_out_t;

  typedef struct packed {
    logic clear_adj;
    logic add_edge;
    logic init_walk;
    logic step;
    logic flush_last;
    logic emit_error;
  } gbt_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic walk_more;
    logic has_cand;
    logic hold_vld;
    logic out_free;
  } gbt_sts_t;

endpackage

[rtl/gbt_datapath.sv]
// ----------------------------------------------------------------------------
// Graph traversal datapath
// Adjacency matrix, visited marks, pending queue or stack, neighbor search,
// configuration registers and the result output register.
// ----------------------------------------------------------------------------
module gbt_datapath import gbt_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  gbt_in_t             in_data_i,
  input  gbt_cmd_t            cmd_i,
  output gbt_sts_t            sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output gbt_out_t            out_data_o
);

  localparam int unsigned ActLim = (MAX_VERTICES < FieldLimit) ? MAX_VERTICES : FieldLimit;
  localparam int unsigned IdxW   = $clog2(ActLim);
  localparam int unsigned PtrW   = $clog2(ActLim + 1);

  function automatic logic [VtxW-1:0] lowest_set(input logic [ActLim-1:0] vec);
    logic [VtxW-1:0] res;
    res = '0;
    for (int i = ActLim - 1; i >= 0; i--) begin
      if (vec[i]) res = VtxW'(i);
    end
    return res;
  endfunction

  logic [CntW-1:0]   vcount_q;
  logic              mode_q;
  logic [ActLim-1:0] adj_q [ActLim];
  logic [ActLim-1:0] visited_q;
  logic [VtxW-1:0]   pend_q [ActLim];
  logic [PtrW-1:0]   head_q, tail_q;
  logic [VtxW-1:0]   hold_q;
  logic              hold_vld_q;
  logic              out_valid_q, out_valid_d;
  gbt_out_t          out_q;

  logic [CntW-1:0]   act_cnt;
  logic [ActLim-1:0] lim_mask;
  logic [PtrW-1:0]   rd_ptr;
  logic [VtxW-1:0]   cur_vtx;
  logic [ActLim-1:0] cand;
  logic [VtxW-1:0]   cand_idx;
  logic              has_cand;
  logic              edge_ok;
  logic              step_emit, step_pop, out_load;
  logic [IdxW-1:0]   a_idx, b_idx;

  assign act_cnt = (vcount_q > CntW'(ActLim)) ? CntW'(ActLim) : vcount_q;

  always_comb begin
    for (int i = 0; i < ActLim; i++) begin
      lim_mask[i] = (CntW'(i) < act_cnt);
    end
  end

  assign a_idx   = in_data_i.first_vertex[IdxW-1:0];
  assign b_idx   = in_data_i.second_vertex[IdxW-1:0];
  assign edge_ok = (CntW'(in_data_i.first_vertex) < CntW'(ActLim)) &&
                   (CntW'(in_data_i.second_vertex) < CntW'(ActLim));

  // Depth first expands the top of stack, breadth first the queue head.
  assign rd_ptr   = (mode_q == ModeDepth) ? (tail_q - PtrW'(1)) : head_q;
  assign cur_vtx  = pend_q[rd_ptr[IdxW-1:0]];
  assign cand     = adj_q[cur_vtx[IdxW-1:0]] & ~visited_q & lim_mask;
  assign has_cand = |cand;
  assign cand_idx = lowest_set(cand);

  assign step_emit = cmd_i.step && has_cand;
  assign step_pop  = cmd_i.step && !has_cand;
  assign out_load  = (step_emit && hold_vld_q) || cmd_i.flush_last || cmd_i.emit_error;

  assign sts_o.start_ok  = CntW'(in_data_i.first_vertex) < act_cnt;
  assign sts_o.walk_more = (mode_q == ModeDepth) ? (tail_q != '0) : (head_q != tail_q);
  assign sts_o.has_cand  = has_cand;
  assign sts_o.hold_vld  = hold_vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountReset;
      mode_q   <= ModeBreadth;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgVertexCount: vcount_q <= cfg_data_i[CntW-1:0];
        CfgWalkMode:    mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ActLim; r++) adj_q[r] <= '0;
    end else if (cmd_i.clear_adj) begin
      for (int r = 0; r < ActLim; r++) adj_q[r] <= '0;
    end else if (cmd_i.add_edge && edge_ok) begin
      adj_q[a_idx][b_idx] <= 1'b1;
      adj_q[b_idx][a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      hold_vld_q <= 1'b0;
    end else begin
      if (cmd_i.init_walk) begin
        visited_q  <= {{(ActLim-1){1'b0}}, 1'b1} << a_idx;
        head_q     <= '0;
        tail_q     <= PtrW'(1);
        hold_vld_q <= 1'b1;
      end else if (step_emit) begin
        visited_q[cand_idx[IdxW-1:0]] <= 1'b1;
        tail_q <= tail_q + PtrW'(1);
      end else if (step_pop) begin
        if (mode_q == ModeDepth) tail_q <= tail_q - PtrW'(1);
        else                     head_q <= head_q + PtrW'(1);
      end
      if (cmd_i.flush_last) hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_walk) begin
      pend_q[0] <= in_data_i.first_vertex;
      hold_q    <= in_data_i.first_vertex;
    end else if (step_emit) begin
      pend_q[tail_q[IdxW-1:0]] <= cand_idx;
      hold_q                   <= cand_idx;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_error) begin
      out_q <= '{vertex: '0, last: 1'b1, error: 1'b1};
    end else if (out_load) begin
      out_q <= '{vertex: hold_q, last: cmd_i.flush_last, error: 1'b0};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/gbt_ctrl.sv]
// ----------------------------------------------------------------------------
// Graph traversal controller
// Accepts requests and sequences the walk, one neighbor search per cycle unless a found neighbor meets a full output.
// ----------------------------------------------------------------------------
module gbt_ctrl import gbt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  req_t     req_type_i,
  output logic     in_ready_o,
  input  gbt_sts_t sts_i,
  output gbt_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [1:0] StErr  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (req_type_i)
            ReqClear: cmd_o.clear_adj = 1'b1;
            ReqEdge:  cmd_o.add_edge  = 1'b1;
            ReqWalk: begin
              if (sts_i.start_ok) begin
                cmd_o.init_walk = 1'b1;
                state_d         = StScan;
              end else begin
                state_d = StErr;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (!sts_i.walk_more) begin
          state_d = StFin;
        end else if (!(sts_i.has_cand && sts_i.hold_vld && !sts_i.out_free)) begin
          // A found neighbor pushes the held vertex out, so it waits for space.
          cmd_o.step = 1'b1;
        end
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.flush_last = 1'b1;
          state_d          = StIdle;
        end
      end
      StErr: begin
        if (sts_i.out_free) begin
          cmd_o.emit_error = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

[rtl/graph_bfs_dfs_traversal.sv]
// ----------------------------------------------------------------------------
// Graph traversal block
// Undirected adjacency matrix with breadth-first and depth-first walks.
// ----------------------------------------------------------------------------
// The block holds an undirected adjacency bit matrix for up to sixteen
// vertices. A clear request empties the matrix and an edge request sets the
// bit for a vertex pair in both rows; neither gives a result. A traverse
// request walks the graph from its start vertex, breadth first with a queue
// or depth first with a stack as the walk mode register selects, always
// taking the lowest-numbered unvisited neighbor below the vertex count
// first. Every visited vertex is sent out as one result transfer in visit
// order, and the final one carries last. A start vertex that is not below
// the vertex count gives a single result with vertex zero, last and error
// set. Each step of a walk reads one adjacency row of the vertex being
// expanded and runs it through a priority encoder, and each vertex costs one
// step when it is found and one more when its row runs out of unvisited
// neighbors. A stalled result output holds the walk only when a new vertex
// is found or the final result waits to go out. The next request is taken
// once the last result of the walk is in the output register; configuration
// is written through the plain write port between requests.
module graph_bfs_dfs_traversal import gbt_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gbt_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gbt_out_t            out_data_o
);

  // Commands from the controller and status back from the datapath.
  gbt_cmd_t cmd;
  gbt_sts_t sts;

  gbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the matrix, the walk state and the output register.
  gbt_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/gbt_checker.sv]
// ----------------------------------------------------------------------------
// Graph traversal port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_bfs_dfs_traversal_macros.svh"

module gbt_checker import gbt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input gbt_in_t  in_data_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input gbt_out_t out_data_i
);

  `GBT_ASSERT_IMPL(a_err_shape, clk_i, rst_ni, out_valid_i && out_data_i.error, out_data_i.last && (out_data_i.vertex == '0), "error result must be a lone last result with vertex zero")
  `GBT_ASSERT_IMPL(a_busy_mid_walk, clk_i, rst_ni, out_valid_i && !out_data_i.last, !in_ready_i, "request taken while a walk is still running")
  `GBT_ASSERT_NEXT(a_walk_blocks, clk_i, rst_ni, in_valid_i && in_ready_i && (in_data_i.req_type == ReqWalk), !in_ready_i, "traverse request did not block the next request")
  `GBT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

[tb/graph_bfs_dfs_traversal_tb.sv]
// ----------------------------------------------------------------------------
// Graph traversal block testbench
// Drives clear, edge and traverse requests with random flow control on both
// sides and checks every visited vertex against a scoreboard that walks its
// own copy of the adjacency matrix.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_tb import gbt_pkg::*;;

  localparam int unsigned MaxV       = MaxVerticesDefault;
  // Request code that the block must drop without a result.
  localparam req_t        ReqUnused  = 2'd3;
  // Cycles without any transfer or register write before the run is abandoned.
  localparam int unsigned StallLimit = 2000;
  // Settle times after a drain: for a clear or edge request, and for a full walk.
  localparam int unsigned PhaseSettle = 4;
  localparam int unsigned EndSettle   = 40;
  localparam int unsigned RandomItems = 330;

  // The scoreboard keeps its own adjacency matrix and register copies, and
  // turns each accepted request into the list of vertices the walk visits.
  class walk_scoreboard;
    logic [MaxV-1:0] adj_rows [MaxV];
    logic [CntW-1:0] vertex_count;
    logic            walk_mode;
    logic [MaxV-1:0] seen_marks;
    logic [VtxW-1:0] pending_vertices [MaxV];
    int              pending_depth;
    gbt_out_t        visit_queue [$];
    int unsigned     fail_count;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vertex_count = VertexCountReset;
      walk_mode    = ModeBreadth;
      fail_count   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] value);
      if (index == CfgVertexCount) vertex_count = value;
      else walk_mode = value[0];
    endfunction

    function int first_unseen(logic [MaxV-1:0] cand);
      for (int i = 0; i < MaxV; i++) begin
        if (cand[i]) return i;
      end
      return -1;
    endfunction

    // Marks a vertex visited, stores it for later expansion and expects it.
    function void take_vertex(int v);
      seen_marks[v] = 1'b1;
      pending_vertices[pending_depth] = v[VtxW-1:0];
      pending_depth++;
      visit_queue.push_back(gbt_out_t'{vertex: v[VtxW-1:0], last: 1'b0, error: 1'b0});
    endfunction

    function void note_request(gbt_in_t req);
      int unsigned     limit;
      logic [MaxV-1:0] reach;
      logic [VtxW-1:0] cur;
      int              head;
      int              nxt;
      case (req.req_type)
        ReqClear: begin
          foreach (adj_rows[i]) adj_rows[i] = '0;
        end
        ReqEdge: begin
          adj_rows[req.first_vertex][req.second_vertex] = 1'b1;
          adj_rows[req.second_vertex][req.first_vertex] = 1'b1;
        end
        ReqWalk: begin
          limit = (32'(vertex_count) > MaxV) ? MaxV : 32'(vertex_count);
          if (32'(req.first_vertex) >= limit) begin
            visit_queue.push_back(gbt_out_t'{vertex: '0, last: 1'b1, error: 1'b1});
            return;
          end
          reach = '0;
          for (int i = 0; i < limit; i++) reach[i] = 1'b1;
          seen_marks    = '0;
          pending_depth = 0;
          head          = 0;
          take_vertex(int'(req.first_vertex));
          if (walk_mode == ModeBreadth) begin
            // Queue: expand vertices in the order they were found.
            while (head < pending_depth) begin
              cur = pending_vertices[head];
              head++;
              nxt = first_unseen(adj_rows[cur] & ~seen_marks & reach);
              while (nxt >= 0) begin
                take_vertex(nxt);
                nxt = first_unseen(adj_rows[cur] & ~seen_marks & reach);
              end
            end
          end else begin
            // Stack: always expand the most recent vertex, pop when exhausted.
            while (pending_depth > 0) begin
              cur = pending_vertices[pending_depth-1];
              nxt = first_unseen(adj_rows[cur] & ~seen_marks & reach);
              if (nxt < 0) pending_depth--;
              else take_vertex(nxt);
            end
          end
          visit_queue[visit_queue.size()-1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_visit(gbt_out_t got);
      gbt_out_t want;
      if (visit_queue.size() == 0) begin
        $error("unexpected result: vertex %0d last %0d error %0d",
               got.vertex, got.last, got.error);
        fail_count++;
        return;
      end
      want = visit_queue.pop_front();
      if (got.vertex !== want.vertex) begin
        $error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0d, got %0d", want.error, got.error);
        fail_count++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  gbt_in_t             in_data     = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  gbt_out_t            out_data;

  // Idle rates in percent for the request side and the result side.
  int unsigned         src_idle_pct  = 27;
  int unsigned         sink_idle_pct = 27;
  int unsigned         requests_sent = 0;
  walk_scoreboard      sb;

  graph_bfs_dfs_traversal i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side. A transfer happens at an edge where valid and ready were both
  // high; the sampled values are the ones from before the edge, since every
  // driver in this bench and in the block updates through nonblocking writes.
  // Ready is redrawn once per edge, so it never gets two updates in one step.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_visit(out_data);
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: a correct run always moves something within the limit, even a
  // sixteen-vertex walk stalled at random on every result.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Presents one request and holds it until the transfer. Valid stays high
  // after the transfer, so back-to-back requests never see valid drop; a
  // random gap lowers it first, which always happens a step later than the
  // edge where it was last raised.
  task automatic send_request(req_t kind, int unsigned first, int unsigned second);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < src_idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= gbt_in_t'{req_type: kind, first_vertex: first[VtxW-1:0],
                          second_vertex: second[VtxW-1:0]};
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(gbt_in_t'{req_type: kind, first_vertex: first[VtxW-1:0],
                              second_vertex: second[VtxW-1:0]});
    if (kind != ReqUnused) requests_sent++;
  endtask

  task automatic add_edge(int unsigned a, int unsigned b);
    send_request(ReqEdge, a, b);
  endtask

  task automatic walk_from(int unsigned v);
    send_request(ReqWalk, v, $urandom_range(0, MaxV-1));
  endtask

  // Holds the request side off until every expected result has been
  // transferred, then lets the block settle. A clear or edge request gives no
  // result, so the extra cycles cover one still in flight.
  task automatic drain(int unsigned settle);
    in_valid <= 1'b0;
    while (sb.visit_queue.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Both registers are rewritten back to back while the block is idle; the
  // scoreboard copy changes at the same edge as the block's.
  task automatic program_walk(int unsigned count, logic mode);
    drain(PhaseSettle);
    cfg_we    <= 1'b1;
    cfg_index <= CfgVertexCount;
    cfg_data  <= count[CfgDataW-1:0];
    @(posedge clk_i);
    sb.write_reg(CfgVertexCount, count[CfgDataW-1:0]);
    cfg_index <= CfgWalkMode;
    cfg_data  <= {{(CfgDataW-1){1'b0}}, mode};
    @(posedge clk_i);
    sb.write_reg(CfgWalkMode, {{(CfgDataW-1){1'b0}}, mode});
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned directed_sent;
    int unsigned round;
    int unsigned count;
    int unsigned span;
    int unsigned pick;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty graph gives single-vertex walks; the small
    // graph below has a diamond, a self loop on vertex 15 and a separate
    // pair, so breadth and depth order differ and the self loop is inert.
    program_walk(16, ModeBreadth);
    walk_from(0);
    walk_from(15);
    add_edge(0, 1);
    add_edge(0, 2);
    add_edge(1, 3);
    add_edge(2, 3);
    add_edge(3, 15);
    add_edge(15, 15);
    add_edge(5, 6);
    send_request(ReqUnused, 15, 15);
    walk_from(0);
    walk_from(15);
    walk_from(5);
    program_walk(16, ModeDepth);
    walk_from(0);
    walk_from(6);
    // A vertex count of four hides vertex 15: the edge to it stays stored but
    // is not followed, and starts at or above the count give an error result.
    program_walk(4, ModeDepth);
    walk_from(4);
    walk_from(0);
    walk_from(15);
    // Zero makes every start an error, and counts above sixteen saturate.
    program_walk(0, ModeBreadth);
    walk_from(0);
    program_walk(31, ModeBreadth);
    walk_from(3);
    program_walk(1, ModeDepth);
    send_request(ReqClear, 15, 0);
    walk_from(0);
    directed_sent = requests_sent;

    // Random part, in rounds: new register settings, usually a cleared graph,
    // a random edge set mostly inside the active vertices, then several walks.
    round = 0;
    while (requests_sent - directed_sent < RandomItems) begin
      // A few rounds run with no idling on either side.
      if (round >= 4 && round <= 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 27;
        sink_idle_pct = 27;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) count = 16;
      else if (pick == 1) count = 1;
      else if (pick == 2) count = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(17, 31);
      else count = $urandom_range(2, 16);
      program_walk(count, 1'($urandom_range(0, 1)));
      span = (count == 0) ? 1 : ((count > MaxV) ? MaxV : count);

      if ($urandom_range(0, 3) != 0) send_request(ReqClear, $urandom_range(0, MaxV-1),
                                                  $urandom_range(0, MaxV-1));
      repeat ($urandom_range(0, 24)) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) send_request(ReqUnused, $urandom_range(0, MaxV-1),
                                    $urandom_range(0, MaxV-1));
        else if (pick == 1) add_edge($urandom_range(0, MaxV-1), $urandom_range(0, MaxV-1));
        else add_edge($urandom_range(0, span-1), $urandom_range(0, span-1));
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 7) == 0) walk_from($urandom_range(0, MaxV-1));
        else walk_from($urandom_range(0, span-1));
      end
      round++;
    end

    drain(EndSettle);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
